// File: hdl/multi_width_crc_engine_unit_macros.svh
// Assertion macros shared by the CRC engine RTL.
`ifndef MULTI_WIDTH_CRC_ENGINE_UNIT_MACROS_SVH
`define MULTI_WIDTH_CRC_ENGINE_UNIT_MACROS_SVH

// Same-cycle implication, checked while out of reset.
`define MWCRC_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked while out of reset.
`define MWCRC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/mwcrc_pkg.sv
// Package with the types, codes and polynomials of the CRC engine.
`timescale 1ns / 1ps
`default_nettype none
package mwcrc_pkg;

  // Width mode codes.
  typedef logic [1:0] crc_mode_t;
  localparam crc_mode_t MODE_CRC8  = 2'd0;
  localparam crc_mode_t MODE_CRC16 = 2'd1;
  localparam crc_mode_t MODE_CRC32 = 2'd2;

  // Configuration register indexes.
  typedef logic [1:0] cfg_index_t;
  localparam cfg_index_t CFG_WIDTH_MODE = 2'd0;
  localparam cfg_index_t CFG_INIT_VALUE = 2'd1;
  localparam cfg_index_t CFG_FINAL_XOR  = 2'd2;

  typedef logic [31:0] crc_word_t;

  // Generator polynomials, top bit implied.
  localparam logic [7:0]  POLY8  = 8'h01;
  localparam logic [15:0] POLY16 = 16'h1021;
  localparam logic [31:0] POLY32 = 32'h04C1_1DB7;

  // Mask that keeps the bits of the selected width.
  function automatic crc_word_t width_mask(input crc_mode_t mode);
    crc_word_t m;
    unique case (mode)
      MODE_CRC8:  m = 32'h0000_00FF;
      MODE_CRC16: m = 32'h0000_FFFF;
      default:    m = 32'hFFFF_FFFF;
    endcase
    return m;
  endfunction

endpackage
`default_nettype wire

// File: hdl/mwcrc_byte_step.sv
// One byte of MSB-first CRC update for the 8, 16 and 32 bit modes.
`timescale 1ns / 1ps
`default_nettype none
module mwcrc_byte_step (
  input  wire mwcrc_pkg::crc_mode_t mode,
  input  wire mwcrc_pkg::crc_word_t crc_in,
  input  wire logic [7:0]           data_byte,
  output mwcrc_pkg::crc_word_t      crc_out
);
  import mwcrc_pkg::*;

  logic [7:0]  c8;
  logic [15:0] c16;
  logic [31:0] c32;

  // Fold the byte into the top of each register and run eight shift steps.
  always_comb begin
    c8  = crc_in[7:0] ^ data_byte;
    c16 = crc_in[15:0] ^ {data_byte, 8'h00};
    c32 = crc_in ^ {data_byte, 24'h00_0000};
    for (int i = 0; i < 8; i++) begin
      c8  = c8[7]   ? ({c8[6:0], 1'b0} ^ POLY8)   : {c8[6:0], 1'b0};
      c16 = c16[15] ? ({c16[14:0], 1'b0} ^ POLY16) : {c16[14:0], 1'b0};
      c32 = c32[31] ? ({c32[30:0], 1'b0} ^ POLY32) : {c32[30:0], 1'b0};
    end
  end

  // Pick the selected width, zero-extended; the unused code acts as CRC-32.
  always_comb begin
    unique case (mode)
      MODE_CRC8:  crc_out = {24'h00_0000, c8};
      MODE_CRC16: crc_out = {16'h0000, c16};
      default:    crc_out = c32;
    endcase
  end

endmodule
`default_nettype wire

// File: hdl/multi_width_crc_engine_unit.sv
// A byte transfer is registered in the input stage, then folded into the running CRC;
// a last byte sets out_valid through the result register once that register is free.
// Throughput: one byte per cycle unless a last byte waits on a full, stalled result register;
// the running CRC register closes its loop through the eight unrolled shift steps.
// Reset: synchronous on rst_n; CRC-32 mode, init value and final XOR zero, running CRC zero.
`timescale 1ns / 1ps
`default_nettype none
`include "multi_width_crc_engine_unit_macros.svh"
module multi_width_crc_engine_unit (
  input  wire                         clk,
  input  wire                         rst_n,
  // Configuration write port
  input  wire                         cfg_we,
  input  wire mwcrc_pkg::cfg_index_t  cfg_index,
  input  wire logic [31:0]            cfg_data,
  // Byte input channel
  input  wire                         in_valid,
  output logic                        in_stall,
  input  wire logic [7:0]             in_data_byte,
  input  wire logic                   in_last_byte,
  // Result channel
  output logic                        out_valid,
  input  wire                         out_stall,
  output logic [31:0]                 out_crc_result
);
  import mwcrc_pkg::*;

  crc_mode_t  width_mode_r;
  crc_word_t  init_value_r;
  crc_word_t  final_xor_r;
  crc_word_t  crc_r;
  crc_word_t  crc_nxt;
  crc_word_t  crc_step;

  logic       s1_valid_r;
  logic [7:0] s1_data_r;
  logic       s1_last_r;
  logic       s1_fire;
  logic       in_take;

  logic       out_valid_r;
  crc_word_t  out_crc_r;
  logic       out_free;
  logic       init_write;

  assign init_write = cfg_we && (cfg_index == CFG_INIT_VALUE);

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_mode_r <= MODE_CRC32;
      init_value_r <= '0;
      final_xor_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_WIDTH_MODE: width_mode_r <= cfg_data[1:0];
        CFG_INIT_VALUE: init_value_r <= cfg_data;
        CFG_FINAL_XOR:  final_xor_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Handshake: a non-last byte always moves on; a last byte needs the result slot.
  assign out_free = !out_valid_r || !out_stall;
  assign s1_fire  = s1_valid_r && (!s1_last_r || out_free);
  assign in_stall = s1_valid_r && !s1_fire;
  assign in_take  = in_valid && !in_stall;

  // Input register stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_take || s1_fire) begin
      s1_valid_r <= in_take;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_data_r <= in_data_byte;
      s1_last_r <= in_last_byte;
    end
  end

  mwcrc_byte_step u_step (
    .mode      (width_mode_r),
    .crc_in    (crc_r),
    .data_byte (s1_data_r),
    .crc_out   (crc_step)
  );

  // Running CRC: an init write reloads it, a last byte restarts from the init value.
  always_comb begin
    crc_nxt = crc_r;
    if (init_write) begin
      crc_nxt = cfg_data;
    end else if (s1_fire) begin
      crc_nxt = s1_last_r ? init_value_r : crc_step;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r <= '0;
    end else begin
      crc_r <= crc_nxt;
    end
  end

  // Result register: loaded with the finished CRC when a last byte completes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_fire && s1_last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_last_r) begin
      out_crc_r <= (crc_step ^ final_xor_r) & width_mask(width_mode_r);
    end
  end

  assign out_valid      = out_valid_r;
  assign out_crc_result = out_crc_r;

  // A stalled input means a last byte waits on a full, stalled result register.
  `MWCRC_ASSERT_NOW(a_stall_cause, clk, rst_n, in_stall,
    s1_valid_r && s1_last_r && out_valid_r && out_stall,
    "input stalled without a blocked last byte")
  // A completing last byte always shows up as a result.
  `MWCRC_ASSERT_NEXT(a_last_gives_result, clk, rst_n, s1_fire && s1_last_r,
    out_valid_r, "last byte did not produce a result")
  // After a last byte the running CRC restarts from the init value.
  `MWCRC_ASSERT_NEXT(a_crc_restart, clk, rst_n, s1_fire && s1_last_r && !init_write,
    crc_r == $past(init_value_r), "running CRC not reloaded after last byte")
  // A middle byte carries its update into the running CRC.
  `MWCRC_ASSERT_NEXT(a_crc_update, clk, rst_n, s1_fire && !s1_last_r && !init_write,
    crc_r == $past(crc_step), "running CRC missed a byte update")

endmodule
`default_nettype wire

// File: dv/crc_tracker_pkg.sv
// Package with the class that predicts and checks the CRC results of the engine.
`timescale 1ns / 1ps
package crc_tracker_pkg;
  import mwcrc_pkg::*;

  class crc_tracker;
    crc_mode_t mode;
    crc_word_t init_word;
    crc_word_t xor_word;
    crc_word_t running;
    crc_word_t expected_crcs[$];
    int errors;

    function new();
      mode = MODE_CRC32;
      init_word = '0;
      xor_word = '0;
      running = '0;
      errors = 0;
    endfunction

    // Bits kept by a width mode; the unused code falls back to 32 bits.
    static function crc_word_t keep_bits(crc_mode_t m);
      case (m)
        MODE_CRC8: return 32'h0000_00FF;
        MODE_CRC16: return 32'h0000_FFFF;
        default: return 32'hFFFF_FFFF;
      endcase
    endfunction

    // One byte into the running CRC, MSB first, eight shift steps.
    static function crc_word_t crc_shift_byte(crc_word_t crc, logic [7:0] value,
                                              crc_mode_t m);
      crc_word_t poly;
      crc_word_t keep;
      int unsigned w;
      case (m)
        MODE_CRC8: begin
          w = 8;
          poly = crc_word_t'(POLY8);
        end
        MODE_CRC16: begin
          w = 16;
          poly = crc_word_t'(POLY16);
        end
        default: begin
          w = 32;
          poly = POLY32;
        end
      endcase
      keep = keep_bits(m);
      crc = (crc & keep) ^ (crc_word_t'(value) << (w - 8));
      for (int i = 0; i < 8; i++) begin
        if (crc[w - 1])
          crc = ((crc << 1) ^ poly) & keep;
        else
          crc = (crc << 1) & keep;
      end
      return crc;
    endfunction

    // A register write; an init write also restarts the running CRC.
    function void write_register(cfg_index_t idx, crc_word_t value);
      case (idx)
        CFG_WIDTH_MODE: mode = value[1:0];
        CFG_INIT_VALUE: begin
          init_word = value;
          running = value;
        end
        CFG_FINAL_XOR: xor_word = value;
        default: ;
      endcase
    endfunction

    // An accepted byte transfer; the last byte of a message yields a result.
    function void note_byte(logic [7:0] value, logic is_last);
      running = crc_shift_byte(running, value, mode);
      if (is_last) begin
        expected_crcs.push_back((running ^ xor_word) & keep_bits(mode));
        running = init_word;
      end
    endfunction

    // An accepted result transfer against the oldest expected CRC.
    function void check_crc(crc_word_t actual);
      crc_word_t want;
      if (expected_crcs.size() == 0) begin
        $error("crc_result: unexpected result %h, expected none", actual);
        errors++;
        return;
      end
      want = expected_crcs.pop_front();
      if (actual !== want) begin
        $error("crc_result mismatch: expected %h, actual %h", want, actual);
        errors++;
      end
    endfunction

    function int pending();
      return expected_crcs.size();
    endfunction
  endclass

endpackage

// File: dv/tb_multi_width_crc_engine_unit.sv
// Testbench of the multi-width CRC engine: directed and random messages checked against a predictor.
`timescale 1ns / 1ps
module tb_multi_width_crc_engine_unit;
  import mwcrc_pkg::*;
  import crc_tracker_pkg::*;

  // Register index with no register behind it, and the spare width mode code.
  localparam cfg_index_t CFG_SPARE = 2'd3;
  localparam crc_mode_t MODE_SPARE = 2'd3;
  // Quiet cycles before the run is declared hung.
  localparam int QUIET_LIMIT = 3000;
  // Cycles that let a byte in flight reach the CRC register.
  localparam int SETTLE_CYCLES = 4;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  cfg_index_t cfg_index = CFG_WIDTH_MODE;
  logic [31:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [7:0] in_data_byte = '0;
  logic in_last_byte = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [31:0] out_crc_result;

  int send_idle_pct = 22;
  int recv_idle_pct = 68;
  crc_tracker crcs = new();

  multi_width_crc_engine_unit u_top (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data_byte(in_data_byte),
    .in_last_byte(in_last_byte),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_crc_result(out_crc_result)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Result side: check each result transfer, then pick the next stall.
  initial begin
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall)
        crcs.check_crc(out_crc_result);
      out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  // Watchdog on cycles with no transfer on either channel.
  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall))
        quiet = 0;
      else
        quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  // One byte transfer, with random idle cycles ahead of it.
  task automatic send_byte(input logic [7:0] value, input logic is_last);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data_byte <= value;
    in_last_byte <= is_last;
    @(posedge clk);
    while (in_stall)
      @(posedge clk);
    crcs.note_byte(value, is_last);
  endtask

  // Register write once every result is out and the last byte has settled.
  task automatic write_register(input cfg_index_t idx, input crc_word_t value);
    in_valid <= 1'b0;
    while (crcs.pending() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    crcs.write_register(idx, value);
    cfg_we <= 1'b0;
  endtask

  // Zero, all ones or a random word.
  function automatic crc_word_t pick_word();
    case ($urandom_range(0, 3))
      0: return '0;
      1: return '1;
      default: return $urandom;
    endcase
  endfunction

  // Random messages; the configuration is rewritten every 40 bytes.
  task automatic run_random(input int count);
    crc_word_t mode_word;
    for (int i = 0; i < count; i++) begin
      if (i % 40 == 0) begin
        mode_word = $urandom;
        mode_word[1:0] = crc_mode_t'($urandom_range(0, 3));
        write_register(CFG_WIDTH_MODE, mode_word);
        write_register(CFG_INIT_VALUE, pick_word());
        write_register(CFG_FINAL_XOR, pick_word());
      end
      send_byte(8'($urandom_range(0, 255)), ($urandom_range(0, 5) == 0));
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset configuration: CRC-32, zero init and final XOR.
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hA5, 1'b1);
    send_byte(8'hFF, 1'b1);

    // CRC-8 with all-ones init and final XOR.
    write_register(CFG_WIDTH_MODE, crc_word_t'(MODE_CRC8));
    write_register(CFG_INIT_VALUE, 32'hFFFF_FFFF);
    write_register(CFG_FINAL_XOR, 32'hFFFF_FFFF);
    send_byte(8'h80, 1'b0);
    send_byte(8'h00, 1'b1);

    // CRC-16; the upper init bits must be ignored.
    write_register(CFG_WIDTH_MODE, crc_word_t'(MODE_CRC16));
    write_register(CFG_INIT_VALUE, 32'h1D0F_FFFF);
    write_register(CFG_FINAL_XOR, 32'h0000_0000);
    send_byte(8'h31, 1'b0);
    send_byte(8'h7F, 1'b1);

    // The spare mode code behaves as CRC-32; upper data bits are ignored.
    write_register(CFG_WIDTH_MODE, {30'h3FFF_FFFF, MODE_SPARE});
    send_byte(8'h01, 1'b1);

    // Width changes in the middle of a message.
    write_register(CFG_WIDTH_MODE, crc_word_t'(MODE_CRC32));
    send_byte(8'hDE, 1'b0);
    send_byte(8'hAD, 1'b0);
    write_register(CFG_WIDTH_MODE, crc_word_t'(MODE_CRC16));
    send_byte(8'hBE, 1'b0);
    write_register(CFG_WIDTH_MODE, crc_word_t'(MODE_CRC8));
    send_byte(8'hEF, 1'b1);

    // An init write in the middle of a message restarts the CRC.
    send_byte(8'h55, 1'b0);
    write_register(CFG_INIT_VALUE, 32'h89AB_CDEF);
    send_byte(8'hAA, 1'b1);

    // A write to the unused index changes nothing.
    send_byte(8'h12, 1'b0);
    write_register(CFG_SPARE, 32'hFFFF_FFFF);
    send_byte(8'h34, 1'b1);

    run_random(135);
    send_idle_pct = 68;
    recv_idle_pct = 22;
    run_random(135);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random(135);

    // Drain the remaining results, then allow the pipeline to settle.
    in_valid <= 1'b0;
    while (crcs.pending() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
    if (crcs.errors == 0 && crcs.pending() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

// File: sim.f
+incdir+hdl
hdl/mwcrc_pkg.sv
hdl/mwcrc_byte_step.sv
hdl/multi_width_crc_engine_unit.sv
dv/crc_tracker_pkg.sv
dv/tb_multi_width_crc_engine_unit.sv
